// File: rtl/core/mie_pkg.sv
// shared types and constants for the modular inverse unit
`timescale 1ns / 1ps
package mie_pkg;
	localparam int DATA_W        = 64;
	localparam int COEF_W        = 64;
	localparam int ALU_W         = 65;
	localparam int STEP_W        = 14;
	localparam int STATUS_W      = 2;
	localparam int WIDTH_DEF     = 64;
	localparam int MAX_STEPS_DEF = 10000;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND   = 2'd0,
		ST_NO_INV  = 2'd1,
		ST_ZERO_OP = 2'd2,
		ST_FAIL    = 2'd3
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [ALU_W-1:0]   a;
		logic [ALU_W-1:0]   b;
	} alu_req_t;
endpackage

// File: rtl/core/mie_in_if.sv
// input channel: value and modulus
`timescale 1ns / 1ps
interface mie_in_if import mie_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] value;
	logic [DATA_W-1:0] modulus;
	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface

// File: rtl/core/mie_out_if.sv
// output channel: inverse, gcd and status
`timescale 1ns / 1ps
interface mie_out_if import mie_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   inverse;
	logic [DATA_W-1:0]   common_divisor;
	logic [STATUS_W-1:0] status;
	modport source (output valid, output inverse, output common_divisor, output status,
		input ready);
	modport sink (input valid, input inverse, input common_divisor, input status,
		output ready);
endinterface

// File: rtl/core/mie_alu.sv
// shared add/subtract unit with carry or borrow out
`timescale 1ns / 1ps
module mie_alu import mie_pkg::*; (
	input  alu_req_t         req,
	output logic [ALU_W:0]   res
);
	// top bit is carry for add, borrow for subtract
	always_comb begin
		if (req.op == ALU_ADD) begin
			res = {1'b0, req.a} + {1'b0, req.b};
		end else begin
			res = {1'b0, req.a} - {1'b0, req.b};
		end
	end
endmodule

// File: rtl/core/modular_inverse_ext_euclid_unit.sv
// Modular inverse by extended Euclid: one item in, one word out.
// Each Euclid step is a restoring division, a shift-add multiply and a coefficient
// update (S_UPDN follows S_UPD on a borrow); the check multiplies the candidate by
// the value modulo m. Value one or a zero operand goes straight to S_DONE.
// Throughput: one item at a time; all datapath sums go through a single 65-bit adder.
// Reset clears the sequencer and the output valid; datapath registers are not reset.
`timescale 1ns / 1ps
module modular_inverse_ext_euclid_unit import mie_pkg::*; #(
	parameter int WIDTH     = WIDTH_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	mie_in_if.sink   in_ch,
	mie_out_if.source out_ch
);
	localparam int CNT_W = $clog2(WIDTH);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_DIV   = 12'b000000000010,
		S_MUL   = 12'b000000000100,
		S_UPD   = 12'b000000001000,
		S_UPDN  = 12'b000000010000,
		S_CAND  = 12'b000000100000,
		S_CRED  = 12'b000001000000,
		S_MADD  = 12'b000010000000,
		S_MADDR = 12'b000100000000,
		S_MDBL  = 12'b001000000000,
		S_MDBLR = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t               state_q;
	logic [WIDTH-1:0]     x_q, m_q, rem_new_q, p_q, quo_q;
	logic [WIDTH-1:0]     cand_q, acc_q, base_q, k_q;
	logic [WIDTH:0]       sum_q;
	logic [COEF_W-1:0]    coef0_mag_q, coef1_mag_q, prod_q;
	logic                 coef0_neg_q, coef1_neg_q;
	logic [STEP_W-1:0]    step_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WIDTH-1:0]     fin_inv_q, fin_gcd_q;
	status_t              fin_status_q;
	logic                 out_valid_q;
	logic [WIDTH-1:0]     out_inv_q, out_gcd_q;
	status_t              out_status_q;

	alu_req_t             req;
	logic [ALU_W:0]       res;
	logic                 borrow;
	logic                 cnt_last;
	logic [WIDTH-1:0]     in_x, in_m, div_p, div_quo;
	logic [COEF_W-1:0]    t_mag;
	logic                 t_neg;

	mie_alu u_alu (.req(req), .res(res));

	assign borrow   = res[ALU_W];
	assign cnt_last = (cnt_q == CNT_W'(WIDTH - 1));
	assign in_x     = in_ch.value[WIDTH-1:0];
	assign in_m     = in_ch.modulus[WIDTH-1:0];

	// operand selection for the shared adder
	always_comb begin
		req.op = ALU_SUB;
		req.a  = '0;
		req.b  = '0;
		case (state_q)
			S_DIV: begin
				req.a = ALU_W'({p_q, quo_q[WIDTH-1]});
				req.b = ALU_W'(rem_new_q);
			end
			S_MUL: begin
				req.op = ALU_ADD;
				req.a  = ALU_W'({prod_q[COEF_W-2:0], 1'b0});
				req.b  = quo_q[WIDTH-1] ? ALU_W'(coef1_mag_q) : '0;
			end
			S_UPD: begin
				req.op = (coef0_neg_q == !coef1_neg_q) ? ALU_ADD : ALU_SUB;
				req.a  = ALU_W'(coef0_mag_q);
				req.b  = ALU_W'(prod_q);
			end
			S_UPDN: begin
				req.a = ALU_W'(prod_q);
				req.b = ALU_W'(coef0_mag_q);
			end
			S_CAND: begin
				req.a = ALU_W'(m_q);
				req.b = ALU_W'(coef1_mag_q[WIDTH-1:0]);
			end
			S_CRED: begin
				req.a = ALU_W'(cand_q);
				req.b = ALU_W'(m_q);
			end
			S_MADD: begin
				req.op = ALU_ADD;
				req.a  = ALU_W'(acc_q);
				req.b  = ALU_W'(base_q);
			end
			S_MDBL: begin
				req.op = ALU_ADD;
				req.a  = ALU_W'(base_q);
				req.b  = ALU_W'(base_q);
			end
			S_MADDR, S_MDBLR: begin
				req.a = ALU_W'(sum_q);
				req.b = ALU_W'(m_q);
			end
			default: begin
				req.op = ALU_SUB;
			end
		endcase
	end

	// restoring division step and new coefficient
	always_comb begin
		div_p   = borrow ? {p_q[WIDTH-2:0], quo_q[WIDTH-1]} : res[WIDTH-1:0];
		div_quo = {quo_q[WIDTH-2:0], !borrow};
		t_mag   = res[COEF_W-1:0];
		if (state_q == S_UPDN) begin
			t_neg = !coef1_neg_q;
		end else begin
			t_neg = coef0_neg_q;
		end
		if (t_mag == '0) begin
			t_neg = 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (in_x == WIDTH'(1)) begin
							state_q <= S_DONE;
						end else if (in_x == '0 || in_m == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
							step_q  <= '0;
						end
					end
				end
				S_DIV: begin
					if (cnt_last) begin
						step_q <= step_q + STEP_W'(1);
						if (div_p == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (cnt_last) begin
						state_q <= S_UPD;
					end
				end
				S_UPD, S_UPDN: begin
					if (state_q == S_UPD && req.op == ALU_SUB && borrow) begin
						state_q <= S_UPDN;
					end else if (p_q == WIDTH'(1)) begin
						state_q <= S_CAND;
					end else if (step_q == STEP_W'(MAX_STEPS)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_CAND: state_q <= S_CRED;
				S_CRED: state_q <= S_MADD;
				S_MADD: begin
					state_q <= k_q[0] ? S_MADDR : S_MDBL;
				end
				S_MADDR: state_q <= S_MDBL;
				S_MDBL:  state_q <= S_MDBLR;
				S_MDBLR: begin
					state_q <= cnt_last ? S_DONE : S_MADD;
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q          <= in_x;
				m_q          <= in_m;
				rem_new_q    <= in_x;
				coef0_mag_q  <= '0;
				coef0_neg_q  <= 1'b0;
				coef1_mag_q  <= COEF_W'(1);
				coef1_neg_q  <= 1'b0;
				p_q          <= '0;
				quo_q        <= in_m;
				cnt_q        <= '0;
				fin_inv_q    <= '0;
				fin_gcd_q    <= '0;
				if (in_x == WIDTH'(1)) begin
					fin_inv_q    <= WIDTH'(1);
					fin_gcd_q    <= WIDTH'(1);
					fin_status_q <= ST_FOUND;
				end else begin
					fin_status_q <= ST_ZERO_OP;
				end
			end
			S_DIV: begin
				p_q   <= div_p;
				quo_q <= div_quo;
				cnt_q <= cnt_last ? '0 : cnt_q + CNT_W'(1);
				if (cnt_last) begin
					prod_q <= '0;
					if (div_p == '0) begin
						fin_gcd_q    <= rem_new_q;
						fin_status_q <= ST_NO_INV;
					end
				end
			end
			S_MUL: begin
				prod_q <= res[COEF_W-1:0];
				quo_q  <= {quo_q[WIDTH-2:0], 1'b0};
				cnt_q  <= cnt_last ? '0 : cnt_q + CNT_W'(1);
			end
			S_UPD, S_UPDN: begin
				if (!(state_q == S_UPD && req.op == ALU_SUB && borrow)) begin
					coef0_mag_q  <= coef1_mag_q;
					coef0_neg_q  <= coef1_neg_q;
					coef1_mag_q  <= t_mag;
					coef1_neg_q  <= t_neg;
					rem_new_q    <= p_q;
					quo_q        <= rem_new_q;
					p_q          <= '0;
					fin_status_q <= ST_FAIL;
				end
			end
			S_CAND: begin
				cand_q <= coef1_neg_q ? res[WIDTH-1:0] : coef1_mag_q[WIDTH-1:0];
			end
			S_CRED: begin
				base_q <= borrow ? cand_q : res[WIDTH-1:0];
				acc_q  <= '0;
				k_q    <= x_q;
				cnt_q  <= '0;
			end
			S_MADD, S_MDBL: begin
				sum_q <= res[WIDTH:0];
			end
			S_MADDR: begin
				acc_q <= borrow ? sum_q[WIDTH-1:0] : res[WIDTH-1:0];
			end
			S_MDBLR: begin
				base_q <= borrow ? sum_q[WIDTH-1:0] : res[WIDTH-1:0];
				k_q    <= k_q >> 1;
				cnt_q  <= cnt_q + CNT_W'(1);
				if (cnt_last) begin
					if (acc_q == WIDTH'(1)) begin
						fin_inv_q    <= cand_q;
						fin_gcd_q    <= WIDTH'(1);
						fin_status_q <= ST_FOUND;
					end else begin
						fin_status_q <= ST_FAIL;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_inv_q    <= fin_inv_q;
					out_gcd_q    <= fin_gcd_q;
					out_status_q <= fin_status_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// ports
	assign in_ch.ready           = (state_q == S_IDLE);
	assign out_ch.valid          = out_valid_q;
	assign out_ch.inverse        = DATA_W'(out_inv_q);
	assign out_ch.common_divisor = DATA_W'(out_gcd_q);
	assign out_ch.status         = out_status_q;

`ifndef SYNTHESIS
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(MAX_STEPS))
		else $error("step count past limit");
	a_found_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FOUND) |-> (out_gcd_q == WIDTH'(1)))
		else $error("found result without unit gcd");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q != S_IDLE))
		else $error("accepted word left sequencer idle");
`endif
endmodule
